### rtl/pdt_pkg.sv
package pdt_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned ModeWidth  = 2;
    localparam int unsigned RepWidth   = 15;
    localparam int unsigned FiresWidth = 16;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    typedef logic [ModeWidth-1:0]   t_mode;
    typedef logic [CfgIdxWidth-1:0] t_cfg_idx;

    localparam t_mode MODE_IDLE     = 2'd0;
    localparam t_mode MODE_ONESHOT  = 2'd1;
    localparam t_mode MODE_INTERVAL = 2'd2;
    localparam t_mode MODE_COUNTED  = 2'd3;

    localparam t_cfg_idx REG_MODE   = 3'd0;
    localparam t_cfg_idx REG_PERIOD = 3'd1;
    localparam t_cfg_idx REG_HALTED = 3'd2;
    localparam t_cfg_idx REG_REPEAT = 3'd3;

endpackage

### rtl/polled_deadline_timer.sv
// Polled deadline timer. Each item on the slave stream is one poll carrying the current
// free-running millisecond time, and each poll yields exactly one result item whose bit 0
// says whether the deadline was reached on that poll. The first active poll arms a deadline
// of now plus period (wrapping modulo 2^32, compared unsigned); one-shot mode fires once,
// interval mode re-arms on the poll after each firing unless halted, and counted mode fires
// repeat_count times and then stays silent. A poll passes the input register and then the
// result register; one poll is accepted every cycle while the result output is not stalled,
// because the timer state is updated by a single add and compare in the result stage.
// Any write to a listed register clears the timer state; write registers only while idle.
module polled_deadline_timer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pdt_pkg::TimeWidth-1:0]        s_axis_tdata,   // [31:0] now_ms
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,   // [0] fired, [7:1] zero
    input  logic                                 i_cfg_wr_en,
    input  pdt_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [pdt_pkg::CfgDataWidth-1:0]     i_cfg_data
);

    // configuration
    pdt_pkg::t_mode                   r_mode;
    logic [pdt_pkg::TimeWidth-1:0]    r_period;
    logic                             r_halted;
    logic [pdt_pkg::RepWidth-1:0]     r_rep;

    // timer state
    logic [pdt_pkg::TimeWidth-1:0]    r_deadline, n_deadline;
    logic                             r_armed, n_armed;
    logic                             r_expired, n_expired;
    logic                             r_rearm_pending, n_rearm_pending;
    logic [pdt_pkg::FiresWidth-1:0]   r_fires_done, n_fires_done;

    // pipeline
    logic                             r_in_valid;
    logic [pdt_pkg::TimeWidth-1:0]    r_in_now;
    logic                             r_out_valid;
    logic                             r_out_fired;

    logic advance;
    logic cfg_hit;
    logic active;
    logic repeating;
    logic cur_armed, cur_expired;
    logic n_fired;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_fired};

    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg_index)
            pdt_pkg::REG_MODE,
            pdt_pkg::REG_PERIOD,
            pdt_pkg::REG_HALTED,
            pdt_pkg::REG_REPEAT: cfg_hit = i_cfg_wr_en;
            default:             cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        active    = 1'b0;
        repeating = 1'b0;
        unique case (r_mode)
            pdt_pkg::MODE_ONESHOT:  active = 1'b1;
            pdt_pkg::MODE_INTERVAL: begin
                active    = !r_halted;
                repeating = 1'b1;
            end
            pdt_pkg::MODE_COUNTED:  begin
                active    = r_fires_done < {1'b0, r_rep};
                repeating = 1'b1;
            end
            default:                active = 1'b0;
        endcase
    end

    // A pending re-arm drops the old deadline before this poll is evaluated.
    always_comb begin
        n_deadline      = r_deadline;
        n_armed         = r_armed;
        n_expired       = r_expired;
        n_rearm_pending = r_rearm_pending;
        n_fires_done    = r_fires_done;
        n_fired         = 1'b0;
        cur_armed       = r_armed && !r_rearm_pending;
        cur_expired     = r_expired && !r_rearm_pending;
        if (active) begin
            if (r_rearm_pending) begin
                n_armed         = 1'b0;
                n_expired       = 1'b0;
                n_rearm_pending = 1'b0;
                if (r_mode == pdt_pkg::MODE_COUNTED) begin
                    n_fires_done = r_fires_done + 1'b1;
                end
            end
            if (!cur_armed && !cur_expired) begin
                n_armed    = 1'b1;
                n_deadline = r_in_now + r_period;
            end else if (r_deadline <= r_in_now && !cur_expired) begin
                n_expired       = 1'b1;
                n_rearm_pending = repeating;
                n_fired         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= pdt_pkg::MODE_IDLE;
            r_period        <= '0;
            r_halted        <= 1'b1;
            r_rep           <= '0;
            r_deadline      <= '0;
            r_armed         <= 1'b0;
            r_expired       <= 1'b0;
            r_rearm_pending <= 1'b0;
            r_fires_done    <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_hit) begin
                unique case (i_cfg_index)
                    pdt_pkg::REG_MODE:   r_mode   <= i_cfg_data[pdt_pkg::ModeWidth-1:0];
                    pdt_pkg::REG_PERIOD: r_period <= i_cfg_data[pdt_pkg::TimeWidth-1:0];
                    pdt_pkg::REG_HALTED: r_halted <= i_cfg_data[0];
                    pdt_pkg::REG_REPEAT: r_rep    <= i_cfg_data[pdt_pkg::RepWidth-1:0];
                    default:             r_mode   <= r_mode;
                endcase
                r_deadline      <= '0;
                r_armed         <= 1'b0;
                r_expired       <= 1'b0;
                r_rearm_pending <= 1'b0;
                r_fires_done    <= '0;
            end else if (advance) begin
                r_deadline      <= n_deadline;
                r_armed         <= n_armed;
                r_expired       <= n_expired;
                r_rearm_pending <= n_rearm_pending;
                r_fires_done    <= n_fires_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_now <= s_axis_tdata;
        end
        if (advance) begin
            r_out_fired <= n_fired;
        end
    end

    a_fire_sets_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_fired && !cfg_hit) |=> r_expired)
        else $error("firing poll did not mark the deadline expired");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == pdt_pkg::MODE_COUNTED) |-> (r_fires_done <= {1'b0, r_rep}))
        else $error("fire count ran past the repeat count");

    a_rearm_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rearm_pending |-> (r_expired && r_mode != pdt_pkg::MODE_ONESHOT))
        else $error("re-arm pending without an expired repeating deadline");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (!r_armed && !r_expired && !r_rearm_pending && r_fires_done == '0))
        else $error("register write did not clear the timer state");

endmodule
